[rtl/i2cm_pkg.sv]
// types, codes and constants shared by the i2c master byte engine
package i2cm_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int HALF_W         = 16;
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd4;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_S_REL  = 4'd1,
        PH_S_HIGH = 4'd2,
        PH_S_LOW  = 4'd3,
        PH_B_LOW  = 4'd4,
        PH_B_HIGH = 4'd5,
        PH_A_LOW  = 4'd6,
        PH_A_HIGH = 4'd7,
        PH_A_END  = 4'd8,
        PH_P_LOW  = 4'd9,
        PH_P_SDA  = 4'd10,
        PH_P_HIGH = 4'd11,
        PH_P_REL  = 4'd12
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       ack_seen;
        logic [7:0] read_byte;
    } res_item_t;

endpackage

[rtl/i2cm_engine.sv]
// bus sequencer: phase state, bit timer, shift register and line drivers
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cmd_item_t         item,
    input  logic [HALF_W-1:0] half_period,
    output res_item_t         result
);

    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic [COUNT_BITS-1:0] tick_count_reg, tick_count_next;
    cmd_t                  active_cmd_reg, active_cmd_next;
    logic                  ack_flag_reg, ack_flag_next;
    logic                  scl_out_reg, scl_out_next;
    logic                  sda_out_reg, sda_out_next;
    logic                  ack_req_reg, ack_req_next;
    logic [7:0]            last_read_reg, last_read_next;

    logic [HALF_W-1:0]     half_eff;
    logic [COUNT_BITS-1:0] half_lim;
    logic [COUNT_BITS-1:0] tick_inc;
    logic                  is_high;
    logic                  go;
    logic                  done;

    // zero counts as one, saturate to the counter range
    assign half_eff = (half_period == '0) ? HALF_W'(1) : half_period;

    generate
        if (COUNT_BITS >= HALF_W) begin : g_wide
            assign half_lim = COUNT_BITS'(half_eff);
        end else begin : g_narrow
            assign half_lim = (|half_eff[HALF_W-1:COUNT_BITS]) ? '1
                                                                 : half_eff[COUNT_BITS-1:0];
        end
    endgenerate

    assign tick_inc = tick_count_reg + COUNT_BITS'(1);
    assign is_high  = (phase_reg == PH_S_HIGH) || (phase_reg == PH_B_HIGH) ||
                      (phase_reg == PH_A_HIGH) || (phase_reg == PH_P_HIGH);

    // next phase and datapath
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        active_cmd_next = active_cmd_reg;
        ack_flag_next   = ack_flag_reg;
        ack_req_next    = ack_req_reg;
        last_read_next  = last_read_reg;
        go              = 1'b0;
        done            = 1'b0;
        if (fire) begin
            if (phase_reg == PH_IDLE) begin
                if (item.kind == CMD_START || item.kind == CMD_STOP ||
                    item.kind == CMD_WRITE || item.kind == CMD_READ) begin
                    active_cmd_next = cmd_t'(item.kind);
                    bit_count_next  = '0;
                    go              = 1'b1;
                    if (item.kind == CMD_START) begin
                        phase_next = PH_S_REL;
                    end else if (item.kind == CMD_STOP) begin
                        phase_next = PH_P_LOW;
                    end else begin
                        shift_next   = (item.kind == CMD_WRITE) ? item.data_byte : 8'd0;
                        ack_req_next = item.send_ack;
                        phase_next   = PH_B_LOW;
                    end
                end
            end else if (!(is_high && !item.scl_in)) begin
                // timer halts while a slave stretches scl
                tick_count_next = tick_inc;
                if (tick_inc >= half_lim) begin
                    unique case (phase_reg)
                        PH_S_REL:
                        begin
                            go = 1'b1; phase_next = PH_S_HIGH;
                        end
                        PH_S_HIGH:
                        begin
                            go = 1'b1; phase_next = PH_S_LOW;
                        end
                        PH_B_LOW:
                        begin
                            go = 1'b1; phase_next = PH_B_HIGH;
                        end
                        PH_B_HIGH:
                        begin
                            shift_next = {shift_reg[6:0],
                                          (active_cmd_reg == CMD_READ) & item.sda_in};
                            bit_count_next = bit_count_reg + 4'd1;
                            go = 1'b1;
                            phase_next = (bit_count_next < BITS_PER_BYTE) ? PH_B_LOW
                                                                          : PH_A_LOW;
                        end
                        PH_A_LOW:
                        begin
                            go = 1'b1; phase_next = PH_A_HIGH;
                        end
                        PH_A_HIGH:
                        begin
                            if (active_cmd_reg == CMD_WRITE) begin
                                ack_flag_next = !item.sda_in;
                            end else begin
                                last_read_next = shift_reg;
                            end
                            go = 1'b1; phase_next = PH_A_END;
                        end
                        PH_P_LOW:
                        begin
                            go = 1'b1; phase_next = PH_P_SDA;
                        end
                        PH_P_SDA:
                        begin
                            go = 1'b1; phase_next = PH_P_HIGH;
                        end
                        PH_P_HIGH:
                        begin
                            go = 1'b1; phase_next = PH_P_REL;
                        end
                        default:
                        begin
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                            active_cmd_next = CMD_NONE;
                            done            = 1'b1;
                        end
                    endcase
                end
            end
            if (go) begin
                tick_count_next = '0;
            end
        end
    end

    // line levels set on entry to a phase
    always_comb
    begin
        scl_out_next = scl_out_reg;
        sda_out_next = sda_out_reg;
        if (go) begin
            unique case (phase_next)
                PH_S_REL:  sda_out_next = 1'b1;
                PH_S_HIGH: scl_out_next = 1'b1;
                PH_S_LOW:  sda_out_next = 1'b0;
                PH_B_LOW:
                begin
                    scl_out_next = 1'b0;
                    sda_out_next = (active_cmd_next == CMD_WRITE) ? shift_next[7] : 1'b1;
                end
                PH_B_HIGH: scl_out_next = 1'b1;
                PH_A_LOW:
                begin
                    scl_out_next = 1'b0;
                    sda_out_next = (active_cmd_next == CMD_WRITE) ? 1'b1 : !ack_req_next;
                end
                PH_A_HIGH: scl_out_next = 1'b1;
                PH_A_END:
                begin
                    scl_out_next = 1'b0;
                    sda_out_next = 1'b1;
                end
                PH_P_LOW:  scl_out_next = 1'b0;
                PH_P_SDA:  sda_out_next = 1'b0;
                PH_P_HIGH: scl_out_next = 1'b1;
                PH_P_REL:  sda_out_next = 1'b1;
                default:
                begin
                    scl_out_next = scl_out_reg;
                    sda_out_next = sda_out_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            tick_count_reg <= '0;
            active_cmd_reg <= CMD_NONE;
            ack_flag_reg   <= 1'b0;
            scl_out_reg    <= 1'b1;
            sda_out_reg    <= 1'b1;
            ack_req_reg    <= 1'b0;
            last_read_reg  <= '0;
        end else begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            active_cmd_reg <= active_cmd_next;
            ack_flag_reg   <= ack_flag_next;
            scl_out_reg    <= scl_out_next;
            sda_out_reg    <= sda_out_next;
            ack_req_reg    <= ack_req_next;
            last_read_reg  <= last_read_next;
        end
    end

    assign result.scl_release = scl_out_next;
    assign result.sda_release = sda_out_next;
    assign result.busy_res    = (phase_next != PH_IDLE);
    assign result.done_res    = done;
    assign result.ack_seen    = ack_flag_next;
    assign result.read_byte   = last_read_next;

endmodule

[rtl/i2c_master_byte_engine_core.sv]
// top level: command register, sequencer, result register and config register
//
// I2C master that takes one item per clock while the command register is not
// stalled: each item is one bus tick with the sampled scl and sda levels and an
// optional start, stop, write or read command, and gives one result item with the
// open-drain line releases and status after that tick. An item passes through the
// command register and then the result register, and a stalled result holds the
// command register so no item is lost.
// the half period in the config register (reset 4) sets the ticks per half scl period;
// write it only while no item is in flight. COUNT_BITS sets the width of the bit timer.
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_item_t         cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output res_item_t         res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [HALF_W-1:0] cfg_data
);

    logic              s1_valid_reg, s1_valid_next;
    cmd_item_t         s1_item_reg;
    logic              res_valid_reg, res_valid_next;
    res_item_t         res_item_reg;
    logic [HALF_W-1:0] half_reg, half_next;
    logic              s1_fire;
    logic              cmd_accept;
    res_item_t         eng_result;

    assign s1_fire    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall  = s1_valid_reg && !s1_fire;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = s1_fire ? 1'b1 : (res_valid_reg && res_stall);
        half_next      = (cfg_valid && cfg_ready) ? cfg_data : half_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            half_reg      <= HALF_RESET;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept) begin
            s1_item_reg <= cmd;
        end
        if (s1_fire) begin
            res_item_reg <= eng_result;
        end
    end

    i2cm_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .item        (s1_item_reg),
        .half_period (half_reg),
        .result      (eng_result)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

endmodule

[rtl/i2cm_checker.sv]
// port-level checks for the i2c master byte engine, bound to the top level
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // a stalled result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result item changed");

    // input is only held back by a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("command stalled without a stalled result");

    // a completing command always returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done reported while still busy");

    // config port never refuses a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

    // stall stays known after an accepted item
    a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> !$isunknown(cmd_stall))
        else $error("stall unknown after accepted item");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
